>>> rtl/psc_pkg.sv
// Package for the PI step-size controller: payload types, control types and constants.
`default_nettype none
package psc_pkg;

  localparam int unsigned ERR_FRAC_BITS = 16;
  localparam int unsigned ERR_W = 32;
  localparam int unsigned STEP_W = 64;

  // error floor 1e-4, rounded to the error format
  localparam logic [ERR_W-1:0] ERR_FLOOR = ERR_W'(((1 << ERR_FRAC_BITS) + 5000) / 10000);
  localparam logic [ERR_W:0]   ERR_ONE   = (ERR_W+1)'(1) << ERR_FRAC_BITS;

  // log/exp constants, 28 fraction bits
  localparam int unsigned LFB = 28;
  localparam logic signed [26:0] ALPHA_Q = 27'sd45634028;
  localparam logic signed [26:0] BETA_Q  = 27'sd10737418;
  localparam logic signed [35:0] LOG2_SAFE_Q = -36'sd40803020;
  localparam logic signed [35:0] EXP_MAX = 36'sd4 <<< LFB;
  localparam logic signed [35:0] EXP_MIN = -(36'sd4 <<< LFB);
  localparam logic [33:0] SCALE_MIN = 34'd53687091;
  localparam logic [33:0] SCALE_MAX = 34'd2684354560;
  localparam logic [33:0] SCALE_ONE = 34'd1 << LFB;

  localparam int unsigned LOG_STEPS = 28;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned EXP_BITS = 28;

  typedef struct packed {
    logic [ERR_W-1:0]  err_ratio;
    logic [STEP_W-1:0] step_size;
  } psc_in_t;

  typedef struct packed {
    logic              accepted;
    logic [STEP_W-1:0] shrunken_step;
    logic [STEP_W-1:0] next_step;
  } psc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_LOG1, ST_TERMA, ST_LOG2, ST_TERMB, ST_EXPI,
    ST_SQI, ST_SQS, ST_SQD, ST_EXPF, ST_MLO, ST_MHI, ST_FIN
  } psc_state_e;

  typedef struct packed {
    logic load_in;
    logic log_init;
    logic log_sel_last;
    logic log_step;
    logic store_a;
    logic store_b;
    logic exp_init;
    logic sq_init;
    logic sq_step;
    logic sq_done;
    logic exp_fin;
    logic mul_lo;
    logic mul_hi;
    logic out_load;
  } psc_cmd_t;

  typedef struct packed {
    logic acc;
    logic err_zero;
    logic out_free;
  } psc_status_t;

endpackage
`default_nettype wire

>>> rtl/psc_ctrl.sv
// Sequencer for the step-size controller: walks the log, exp and multiply phases.
`default_nettype none
module psc_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire psc_pkg::psc_status_t status_i,
  output psc_pkg::psc_cmd_t         cmd_o
);

  psc_pkg::psc_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [4:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psc_pkg::ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    unique case (state_q)
      psc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = psc_pkg::ST_DEC;
      end
      psc_pkg::ST_DEC: begin
        cnt_d = '0;
        if (status_i.err_zero) state_d = psc_pkg::ST_EXPF;
        else state_d = psc_pkg::ST_LOG1;
      end
      psc_pkg::ST_LOG1: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(psc_pkg::LOG_STEPS - 1)) state_d = psc_pkg::ST_TERMA;
      end
      psc_pkg::ST_TERMA: begin
        cnt_d = '0;
        if (status_i.acc) state_d = psc_pkg::ST_LOG2;
        else state_d = psc_pkg::ST_EXPI;
      end
      psc_pkg::ST_LOG2: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(psc_pkg::LOG_STEPS - 1)) state_d = psc_pkg::ST_TERMB;
      end
      psc_pkg::ST_TERMB: state_d = psc_pkg::ST_EXPI;
      psc_pkg::ST_EXPI: begin
        k_d     = '0;
        state_d = psc_pkg::ST_SQI;
      end
      psc_pkg::ST_SQI: begin
        cnt_d   = '0;
        state_d = psc_pkg::ST_SQS;
      end
      psc_pkg::ST_SQS: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(psc_pkg::SQRT_STEPS - 1)) state_d = psc_pkg::ST_SQD;
      end
      psc_pkg::ST_SQD: begin
        k_d = k_q + 5'd1;
        if (k_q == 5'(psc_pkg::EXP_BITS - 1)) state_d = psc_pkg::ST_EXPF;
        else state_d = psc_pkg::ST_SQI;
      end
      psc_pkg::ST_EXPF: state_d = psc_pkg::ST_MLO;
      psc_pkg::ST_MLO:  state_d = psc_pkg::ST_MHI;
      psc_pkg::ST_MHI:  state_d = psc_pkg::ST_FIN;
      psc_pkg::ST_FIN: begin
        if (status_i.out_free) state_d = psc_pkg::ST_IDLE;
      end
      default: state_d = psc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      psc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      psc_pkg::ST_DEC:   cmd_o.log_init = 1'b1;
      psc_pkg::ST_LOG1:  cmd_o.log_step = 1'b1;
      psc_pkg::ST_TERMA: begin
        cmd_o.store_a      = 1'b1;
        cmd_o.log_init     = 1'b1;
        cmd_o.log_sel_last = 1'b1;
      end
      psc_pkg::ST_LOG2:  cmd_o.log_step = 1'b1;
      psc_pkg::ST_TERMB: cmd_o.store_b = 1'b1;
      psc_pkg::ST_EXPI:  cmd_o.exp_init = 1'b1;
      psc_pkg::ST_SQI:   cmd_o.sq_init = 1'b1;
      psc_pkg::ST_SQS:   cmd_o.sq_step = 1'b1;
      psc_pkg::ST_SQD:   cmd_o.sq_done = 1'b1;
      psc_pkg::ST_EXPF:  cmd_o.exp_fin = 1'b1;
      psc_pkg::ST_MLO:   cmd_o.mul_lo = 1'b1;
      psc_pkg::ST_MHI:   cmd_o.mul_hi = 1'b1;
      psc_pkg::ST_FIN:   cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/psc_dp.sv
// Datapath for the step-size controller: log2 squarer, exp2 root chain, step multiply.
`default_nettype none
module psc_dp (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire psc_pkg::psc_in_t  in_data_i,
  input  wire psc_pkg::psc_cmd_t cmd_i,
  output psc_pkg::psc_status_t   status_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output psc_pkg::psc_out_t      out_data_o
);

  logic [31:0] err_q, last_err_q;
  logic [63:0] h_q;
  logic        acc_q, zero_q, reject_q, out_valid_q;
  logic [31:0] m_q;
  logic signed [5:0] pm_q;
  logic [27:0] frac_q;
  logic signed [32:0] term_a_q, term_b_q;
  logic signed [3:0]  n_q;
  logic [27:0] f_q;
  logic [31:0] r_q, scale_q;
  logic [63:0] v_q, res_q, bit_q, hi_q;
  logic [37:0] lo_q;
  psc_pkg::psc_out_t out_q;

  // leading one of the log operand
  logic [31:0] log_x;
  logic [4:0]  lead;
  always_comb begin
    log_x = cmd_i.log_sel_last ? last_err_q : err_q;
    if (log_x == '0) log_x = 32'd1;
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (log_x[i]) lead = 5'(i);
    end
  end

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    if (cmd_i.log_step) begin
      mul_a = m_q;
      mul_b = m_q;
    end else begin
      mul_a = cmd_i.mul_hi ? h_q[63:32] : h_q[31:0];
      mul_b = scale_q;
    end
    prod = mul_a * mul_b;
  end
  logic [32:0] sq_t;
  assign sq_t = prod[63:31];

  // log value times alpha or beta
  logic signed [33:0] log_val;
  logic signed [26:0] coef;
  logic signed [60:0] term_prod;
  logic signed [32:0] term;
  assign log_val   = {pm_q, frac_q};
  assign coef      = cmd_i.store_b ? psc_pkg::BETA_Q : psc_pkg::ALPHA_Q;
  assign term_prod = log_val * coef;
  assign term      = 33'(term_prod >>> psc_pkg::LFB);

  logic signed [35:0] e_raw, e_cl;
  always_comb begin
    e_raw = psc_pkg::LOG2_SAFE_Q - 36'(term_a_q) + (acc_q ? 36'(term_b_q) : 36'sd0);
    if (e_raw < psc_pkg::EXP_MIN) e_cl = psc_pkg::EXP_MIN;
    else if (e_raw > psc_pkg::EXP_MAX) e_cl = psc_pkg::EXP_MAX;
    else e_cl = e_raw;
  end

  // one step of the integer square root
  logic [63:0] trial;
  assign trial = res_q + bit_q;

  logic [32:0] r_in;
  assign r_in = f_q[0] ? {r_q, 1'b0} : {1'b0, r_q};

  // exp2 result, shifted and bounded
  logic [35:0] shifted;
  logic [33:0] sc, sc_b;
  always_comb begin
    if (!n_q[3]) shifted = {4'b0, r_q} << n_q[2:0];
    else shifted = {4'b0, r_q} >> 3'(-n_q);
    sc = shifted[35:2];
    if (zero_q) sc_b = psc_pkg::SCALE_MAX;
    else if (sc < psc_pkg::SCALE_MIN) sc_b = psc_pkg::SCALE_MIN;
    else if (acc_q && sc > psc_pkg::SCALE_MAX) sc_b = psc_pkg::SCALE_MAX;
    else sc_b = sc;
    if (acc_q && reject_q && sc_b > psc_pkg::SCALE_ONE) sc_b = psc_pkg::SCALE_ONE;
  end

  logic [68:0] sum;
  logic [63:0] prod_sat;
  assign sum      = {1'b0, hi_q, 4'b0} + 69'(lo_q);
  assign prod_sat = (sum[68:64] != '0) ? '1 : sum[63:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      err_q  <= in_data_i.err_ratio;
      h_q    <= in_data_i.step_size;
      acc_q  <= {1'b0, in_data_i.err_ratio} <= psc_pkg::ERR_ONE;
      zero_q <= in_data_i.err_ratio == '0;
    end
    if (cmd_i.log_init) begin
      m_q    <= log_x << (5'd31 - lead);
      pm_q   <= $signed({1'b0, lead}) - 6'sd16;
      frac_q <= '0;
    end else if (cmd_i.log_step) begin
      if (sq_t[32]) begin
        m_q    <= sq_t[32:1];
        frac_q <= {frac_q[26:0], 1'b1};
      end else begin
        m_q    <= sq_t[31:0];
        frac_q <= {frac_q[26:0], 1'b0};
      end
    end
    if (cmd_i.store_a) term_a_q <= term;
    if (cmd_i.store_b) term_b_q <= term;
    if (cmd_i.exp_init) begin
      n_q <= 4'(e_cl >>> psc_pkg::LFB);
      f_q <= e_cl[27:0];
      r_q <= 32'd1 << 30;
    end
    if (cmd_i.sq_init) begin
      v_q   <= {r_in, 31'b0} >> 1;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
      f_q   <= f_q >> 1;
    end else if (cmd_i.sq_step) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.sq_done) r_q <= res_q[31:0];
    if (cmd_i.exp_fin) scale_q <= sc_b[31:0];
    if (cmd_i.mul_lo) lo_q <= prod[63:26] >> 2;
    if (cmd_i.mul_hi) hi_q <= prod;
    if (cmd_i.out_load) begin
      out_q.accepted      <= acc_q;
      out_q.shrunken_step <= acc_q ? h_q : prod_sat;
      out_q.next_step     <= acc_q ? prod_sat : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= psc_pkg::ERR_FLOOR;
      reject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        reject_q    <= !acc_q;
        if (acc_q) last_err_q <= (err_q > psc_pkg::ERR_FLOOR) ? err_q : psc_pkg::ERR_FLOOR;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.acc      = acc_q;
  assign status_o.err_zero = zero_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule
`default_nettype wire

>>> rtl/pi_step_size_controller_unit.sv
// Top level of the PI step-size controller: sequencer plus datapath.
// Usage:
//   Input channel in_valid_i/in_ready_o carries an error ratio (Q16.16) and
//   the current step (Q16.48). Output channel out_valid_o/out_ready_i returns
//   the accept flag, the shrunken step and the proposed next step.
//   One item is in work at a time; in_ready_o is high while the sequencer idles.
//   Time from input transfer to result valid is set by the shared squarer and
//   the bit-serial square root in the exp2 chain:
//     zero error:      skips both log2 passes and the exp2 root chain
//     rejected step:   one log2 pass, then the exp2 root chain and the multiply
//     accepted step:   as a rejected step, plus a second log2 pass
//   The next item may be taken while the previous result is valid.
//   A result waits in the output register while the receiver stalls; the next
//   item may be taken and worked on, and it holds in its final state until the
//   output register is free.
//   Reset sets the stored error to the 1e-4 floor, clears the reject flag and
//   empties the output register.
`default_nettype none
module pi_step_size_controller_unit (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire psc_pkg::psc_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output psc_pkg::psc_out_t     out_data_o
);

  psc_pkg::psc_cmd_t    cmd;
  psc_pkg::psc_status_t status;

  psc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
